FILE: hw/rtl/cftm_pkg.sv
// package: constants, types and codes of the can frame timing monitor
`timescale 1ns / 1ps
package cftm_pkg;

  localparam int AXES         = 2;
  localparam int AXIS_W       = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int WORDS_AXIS   = 14;
  localparam int NWORDS       = 2 + WORDS_AXIS * AXES;
  localparam int IDX_W        = 5;
  localparam int WRD_W        = 4;
  localparam int CFG_AW       = 2;
  localparam int QDEPTH       = 2;

  localparam logic [31:0] LIMIT_RESET   = 32'd50000;
  localparam logic [4:0]  CNUM_HEARTBEAT = 5'h01;
  localparam logic [4:0]  CNUM_ENCODER   = 5'h09;
  localparam logic [3:0]  LEN_ENCODER    = 4'd8;
  localparam logic [3:0]  LEN_HEARTBEAT  = 4'd5;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TX    = 2'd1;
  localparam logic [1:0] CMD_SNAP  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_LIMIT = '0;

  // word offsets inside one axis block of a snapshot
  localparam logic [WRD_W-1:0] W_FRAMES  = 4'd0;
  localparam logic [WRD_W-1:0] W_IMIN    = 4'd1;
  localparam logic [WRD_W-1:0] W_IMAX    = 4'd2;
  localparam logic [WRD_W-1:0] W_ISUM    = 4'd3;
  localparam logic [WRD_W-1:0] W_ICNT    = 4'd4;
  localparam logic [WRD_W-1:0] W_LMIN    = 4'd5;
  localparam logic [WRD_W-1:0] W_LMAX    = 4'd6;
  localparam logic [WRD_W-1:0] W_LSUM    = 4'd7;
  localparam logic [WRD_W-1:0] W_LCNT    = 4'd8;
  localparam logic [WRD_W-1:0] W_HBCNT   = 4'd9;
  localparam logic [WRD_W-1:0] W_ERR     = 4'd10;
  localparam logic [WRD_W-1:0] W_MODE    = 4'd11;
  localparam logic [WRD_W-1:0] W_POS     = 4'd12;
  localparam logic [WRD_W-1:0] W_VEL     = 4'd13;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_ENCODER = 3'd1,
    OP_HEART   = 3'd2,
    OP_TX_OK   = 3'd3,
    OP_TX_FAIL = 3'd4,
    OP_SNAP    = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [AXIS_W-1:0] axis;
    logic [31:0]       data_low;
    logic [31:0]       data_high;
    logic [31:0]       time_us;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DUMP = 4'b1000
  } back_state_t;

endpackage

FILE: hw/rtl/cftm_if.sv
// channel interfaces for events in and statistic words out
`timescale 1ns / 1ps
interface cftm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] frame_id;
  logic [3:0]  payload_len;
  logic [31:0] data_low;
  logic [31:0] data_high;
  logic        tx_axis;
  logic        tx_ok;
  logic [31:0] time_us;
  modport source(output valid, command, frame_id, payload_len, data_low, data_high,
                 tx_axis, tx_ok, time_us, input ready);
  modport sink(input valid, command, frame_id, payload_len, data_low, data_high,
               tx_axis, tx_ok, time_us, output ready);
endinterface

interface cftm_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  stat_index;
  logic [63:0] stat_value;
  logic        last;
  modport source(output valid, stat_index, stat_value, last, input ready);
  modport sink(input valid, stat_index, stat_value, last, output ready);
endinterface

FILE: hw/rtl/cftm_front.sv
// front end: decodes events into operations and queues them for the back end
`timescale 1ns / 1ps
module cftm_front import cftm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cftm_in_if.sink     in_ch,
  output logic        q_valid,
  output op_t         q_op,
  input  logic        q_pop
);

  op_t                      q_mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wr_ptr_r, rd_ptr_r;
  logic [$clog2(QDEPTH):0]   cnt_r;
  op_t                      op_c;
  logic [5:0]               node;
  logic [4:0]               cnum;
  logic                     push, pop;

  assign node = in_ch.frame_id[10:5];
  assign cnum = in_ch.frame_id[4:0];

  always_comb begin
    op_c.kind      = OP_NOP;
    op_c.axis      = in_ch.tx_axis;
    op_c.data_low  = in_ch.data_low;
    op_c.data_high = in_ch.data_high;
    op_c.time_us   = in_ch.time_us;
    case (in_ch.command)
      CMD_FRAME: begin
        op_c.axis = node[AXIS_W-1:0];
        if (32'(node) < AXES) begin
          if (cnum == CNUM_ENCODER && in_ch.payload_len >= LEN_ENCODER)
            op_c.kind = OP_ENCODER;
          else if (cnum == CNUM_HEARTBEAT && in_ch.payload_len >= LEN_HEARTBEAT)
            op_c.kind = OP_HEART;
        end
      end
      CMD_TX: begin
        if (32'(in_ch.tx_axis) < AXES)
          op_c.kind = in_ch.tx_ok ? OP_TX_OK : OP_TX_FAIL;
      end
      CMD_SNAP: op_c.kind = OP_SNAP;
      default:  op_c.kind = OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r < ($clog2(QDEPTH)+1)'(QDEPTH));
  // operations that change nothing are dropped here
  assign push    = in_ch.valid && in_ch.ready && (op_c.kind != OP_NOP);
  assign q_valid = (cnt_r != '0);
  assign q_op    = q_mem_r[rd_ptr_r];
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= op_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
    end
  end

endmodule

FILE: hw/rtl/cftm_back.sv
// back end: per-axis statistics, transmit counters and snapshot streaming
`timescale 1ns / 1ps
module cftm_back import cftm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  op_t         q_op,
  output logic        q_pop,
  input  logic [31:0] limit,
  cftm_out_if.source  out_ch
);

  back_state_t state_r;
  op_t         op_r;

  logic [31:0] pos_r [AXES], vel_r [AXES], frames_r [AXES], last_t_r [AXES];
  logic [31:0] imin_r [AXES], imax_r [AXES], icnt_r [AXES], hb_r [AXES];
  logic [63:0] isum_r [AXES], lsum_r [AXES];
  logic [31:0] err_r [AXES], pend_r [AXES], lmin_r [AXES], lmax_r [AXES], lcnt_r [AXES];
  logic [7:0]  mode_r [AXES];
  logic [31:0] tx_sent_r, tx_fail_r;

  logic [31:0] dt_r, lat_r;
  logic        dt_v_r, lat_take_r, lat_ok_r;

  logic [IDX_W-1:0]  idx_r;
  logic [WRD_W-1:0]  wrd_r;
  logic [AXIS_W-1:0] dax_r;

  logic              out_v_r, out_last_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [63:0]       out_val_r;

  logic [AXIS_W-1:0] ra;
  logic              load, last_word, clr;
  logic [63:0]       word;
  logic [31:0]       pend_sel, last_sel;

  assign ra       = (state_r == ST_DUMP) ? dax_r : op_r.axis;
  assign pend_sel = pend_r[ra];
  assign last_sel = last_t_r[ra];

  assign q_pop     = (state_r == ST_IDLE);
  assign load      = (state_r == ST_DUMP) && (!out_v_r || out_ch.ready);
  assign last_word = (idx_r == IDX_W'(NWORDS - 1));
  assign clr       = load && last_word;

  always_comb begin
    word = '0;
    if (idx_r == IDX_W'(0)) word = {32'd0, tx_sent_r};
    else if (idx_r == IDX_W'(1)) word = {32'd0, tx_fail_r};
    else begin
      case (wrd_r)
        W_FRAMES: word = {32'd0, frames_r[ra]};
        W_IMIN:   word = {32'd0, (icnt_r[ra] != '0) ? imin_r[ra] : 32'd0};
        W_IMAX:   word = {32'd0, imax_r[ra]};
        W_ISUM:   word = isum_r[ra];
        W_ICNT:   word = {32'd0, icnt_r[ra]};
        W_LMIN:   word = {32'd0, (lcnt_r[ra] != '0) ? lmin_r[ra] : 32'd0};
        W_LMAX:   word = {32'd0, lmax_r[ra]};
        W_LSUM:   word = lsum_r[ra];
        W_LCNT:   word = {32'd0, lcnt_r[ra]};
        W_HBCNT:  word = {32'd0, hb_r[ra]};
        W_ERR:    word = {32'd0, err_r[ra]};
        W_MODE:   word = {56'd0, mode_r[ra]};
        W_POS:    word = {32'd0, pos_r[ra]};
        W_VEL:    word = {32'd0, vel_r[ra]};
        default:  word = '0;
      endcase
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.stat_index = out_idx_r;
  assign out_ch.stat_value = out_val_r;
  assign out_ch.last       = out_last_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) op_r <= q_op;
    if (state_r == ST_CALC) begin
      dt_r       <= op_r.time_us - last_sel;
      dt_v_r     <= (last_sel != '0);
      lat_r      <= op_r.time_us - pend_sel;
      lat_take_r <= (pend_sel != '0) && (op_r.time_us > pend_sel);
      lat_ok_r   <= ((op_r.time_us - pend_sel) < limit);
    end
    if (load) begin
      out_idx_r  <= idx_r;
      out_val_r  <= word;
      out_last_r <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_v_r   <= 1'b0;
      idx_r     <= '0;
      wrd_r     <= '0;
      dax_r     <= '0;
      tx_sent_r <= '0;
      tx_fail_r <= '0;
      for (int i = 0; i < AXES; i++) begin
        pos_r[i] <= '0; vel_r[i] <= '0; frames_r[i] <= '0; last_t_r[i] <= '0;
        imin_r[i] <= '1; imax_r[i] <= '0; isum_r[i] <= '0; icnt_r[i] <= '0;
        hb_r[i] <= '0; err_r[i] <= '0; mode_r[i] <= '0; pend_r[i] <= '0;
        lmin_r[i] <= '1; lmax_r[i] <= '0; lsum_r[i] <= '0; lcnt_r[i] <= '0;
      end
    end else begin
      if (load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (q_valid) state_r <= (q_op.kind == OP_SNAP) ? ST_DUMP : ST_CALC;
          idx_r <= '0;
          wrd_r <= '0;
          dax_r <= '0;
        end
        ST_CALC: state_r <= ST_UPD;
        ST_UPD: begin
          state_r <= ST_IDLE;
          case (op_r.kind)
            OP_ENCODER: begin
              pos_r[op_r.axis]    <= op_r.data_low;
              vel_r[op_r.axis]    <= op_r.data_high;
              last_t_r[op_r.axis] <= op_r.time_us;
              frames_r[op_r.axis] <= frames_r[op_r.axis] + 32'd1;
              if (dt_v_r) begin
                if (dt_r < imin_r[op_r.axis]) imin_r[op_r.axis] <= dt_r;
                if (dt_r > imax_r[op_r.axis]) imax_r[op_r.axis] <= dt_r;
                isum_r[op_r.axis] <= isum_r[op_r.axis] + {32'd0, dt_r};
                icnt_r[op_r.axis] <= icnt_r[op_r.axis] + 32'd1;
              end
              // pending send time is used up even when the sample is discarded
              if (lat_take_r) begin
                pend_r[op_r.axis] <= '0;
                if (lat_ok_r) begin
                  if (lat_r < lmin_r[op_r.axis]) lmin_r[op_r.axis] <= lat_r;
                  if (lat_r > lmax_r[op_r.axis]) lmax_r[op_r.axis] <= lat_r;
                  lsum_r[op_r.axis] <= lsum_r[op_r.axis] + {32'd0, lat_r};
                  lcnt_r[op_r.axis] <= lcnt_r[op_r.axis] + 32'd1;
                end
              end
            end
            OP_HEART: begin
              err_r[op_r.axis]  <= op_r.data_low;
              mode_r[op_r.axis] <= op_r.data_high[7:0];
              hb_r[op_r.axis]   <= hb_r[op_r.axis] + 32'd1;
            end
            OP_TX_OK: begin
              pend_r[op_r.axis] <= op_r.time_us;
              tx_sent_r         <= tx_sent_r + 32'd1;
            end
            OP_TX_FAIL: tx_fail_r <= tx_fail_r + 32'd1;
            default: ;
          endcase
        end
        ST_DUMP: begin
          if (load) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r >= IDX_W'(2)) begin
              if (wrd_r == WRD_W'(WORDS_AXIS - 1)) begin
                wrd_r <= '0;
                dax_r <= dax_r + 1'b1;
              end else begin
                wrd_r <= wrd_r + 1'b1;
              end
            end
          end
          if (clr) begin
            state_r   <= ST_IDLE;
            tx_sent_r <= '0;
            tx_fail_r <= '0;
            for (int i = 0; i < AXES; i++) begin
              frames_r[i] <= '0; imin_r[i] <= '1; imax_r[i] <= '0; isum_r[i] <= '0;
              icnt_r[i] <= '0; hb_r[i] <= '0; lmin_r[i] <= '1; lmax_r[i] <= '0;
              lsum_r[i] <= '0; lcnt_r[i] <= '0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/can_axis_frame_timing_monitor.sv
// top level of the can frame timing monitor
`timescale 1ns / 1ps
// Watches can traffic of two motor axes. Every input transfer is one event:
// a received frame, a transmit outcome or a snapshot request. Events enter a
// two-entry queue; the front end accepts one per cycle while the queue has
// room. An encoder, heartbeat or transmit event goes through the back-end
// steps fetch, difference and compare, update; events that change nothing are
// dropped at the front and cost no back-end time. A snapshot streams 30
// words, one per cycle while the sink takes them, the last one flagged, and
// then clears the window counters. The latency limit register sits at byte
// address 0 and may only be written while no events are in flight.
module can_axis_frame_timing_monitor import cftm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cftm_in_if.sink           in_ch,
  cftm_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] limit_r;
  logic        q_valid, q_pop;
  op_t         q_op;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LIMIT) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (psel && penable && pwrite && paddr == REG_LIMIT) limit_r <= pwdata;
  end

  cftm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  cftm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .limit   (limit_r),
    .out_ch  (out_ch)
  );

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.stat_index == IDX_W'(NWORDS - 1))
    else $error("last flag on wrong word");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=>
      out_ch.valid && out_ch.stat_index == IDX_W'($past(out_ch.stat_index) + 1'b1))
    else $error("snapshot words not consecutive");

  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=>
      !out_ch.valid || out_ch.stat_index == '0)
    else $error("snapshot did not start at word zero");

endmodule

FILE: test/tb_top.sv
// testbench for the can frame timing monitor: directed and random events checked against a predictor
`timescale 1ns / 1ps
module tb_top import cftm_pkg::*; ();

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  cftm_in_if  ev_ch();
  cftm_out_if st_ch();

  can_axis_frame_timing_monitor i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(ev_ch.sink), .out_ch(st_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    logic [4:0]  idx;
    logic [63:0] value;
    logic        last;
  } stat_word_t;

  typedef struct {
    logic [31:0] pos, vel, frames, last_rx, imin, imax;
    logic [63:0] isum;
    logic [31:0] icnt, hbcnt, err;
    logic [7:0]  mode;
    logic [31:0] pend, lmin, lmax;
    logic [63:0] lsum;
    logic [31:0] lcnt;
  } axis_model_t;

  axis_model_t mon_ax[AXES];
  logic [31:0] mon_sent, mon_failed, mon_limit;
  stat_word_t  stat_expected[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  hold_cycles = 0;
  logic [31:0] now_us = 32'd1000;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void clear_window_model();
    for (int i = 0; i < AXES; i++) begin
      mon_ax[i].frames = 0; mon_ax[i].imin = '1; mon_ax[i].imax = 0;
      mon_ax[i].isum = 0; mon_ax[i].icnt = 0; mon_ax[i].hbcnt = 0;
      mon_ax[i].lmin = '1; mon_ax[i].lmax = 0; mon_ax[i].lsum = 0; mon_ax[i].lcnt = 0;
    end
    mon_sent = 0;
    mon_failed = 0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < AXES; i++) begin
      mon_ax[i].pos = 0; mon_ax[i].vel = 0; mon_ax[i].last_rx = 0;
      mon_ax[i].err = 0; mon_ax[i].mode = 0; mon_ax[i].pend = 0;
    end
    clear_window_model();
    mon_limit = LIMIT_RESET;
  endfunction

  function automatic void push_stat(int k, logic [63:0] v);
    stat_word_t w;
    w.idx = k[4:0];
    w.value = v;
    w.last = (k == NWORDS - 1);
    stat_expected.push_back(w);
  endfunction

  // updates the model for one event and queues any snapshot words
  function automatic void predict_event(logic [1:0] cmd, logic [10:0] id, logic [3:0] len,
                                        logic [31:0] lo, logic [31:0] hi, logic txa,
                                        logic txok, logic [31:0] t);
    int n;
    int k;
    logic [31:0] dt;
    n = int'(id[10:5]);
    if (cmd == CMD_FRAME) begin
      if (n < AXES) begin
        if (id[4:0] == CNUM_ENCODER && len >= LEN_ENCODER) begin
          mon_ax[n].pos = lo;
          mon_ax[n].vel = hi;
          if (mon_ax[n].last_rx != 0) begin
            dt = t - mon_ax[n].last_rx;
            if (dt < mon_ax[n].imin) mon_ax[n].imin = dt;
            if (dt > mon_ax[n].imax) mon_ax[n].imax = dt;
            mon_ax[n].isum += 64'(dt);
            mon_ax[n].icnt++;
          end
          mon_ax[n].last_rx = t;
          mon_ax[n].frames++;
          if (mon_ax[n].pend != 0 && t > mon_ax[n].pend) begin
            dt = t - mon_ax[n].pend;
            if (dt < mon_limit) begin
              if (dt < mon_ax[n].lmin) mon_ax[n].lmin = dt;
              if (dt > mon_ax[n].lmax) mon_ax[n].lmax = dt;
              mon_ax[n].lsum += 64'(dt);
              mon_ax[n].lcnt++;
            end
            mon_ax[n].pend = 0;
          end
        end else if (id[4:0] == CNUM_HEARTBEAT && len >= LEN_HEARTBEAT) begin
          mon_ax[n].err = lo;
          mon_ax[n].mode = hi[7:0];
          mon_ax[n].hbcnt++;
        end
      end
    end else if (cmd == CMD_TX) begin
      if (txa < AXES) begin
        if (txok) begin
          mon_ax[txa].pend = t;
          mon_sent++;
        end else mon_failed++;
      end
    end else if (cmd == CMD_SNAP) begin
      push_stat(0, 64'(mon_sent));
      push_stat(1, 64'(mon_failed));
      for (int a = 0; a < AXES; a++) begin
        k = 2 + WORDS_AXIS * a;
        push_stat(k + int'(W_FRAMES), 64'(mon_ax[a].frames));
        push_stat(k + int'(W_IMIN), 64'(mon_ax[a].icnt != 0 ? mon_ax[a].imin : 32'd0));
        push_stat(k + int'(W_IMAX), 64'(mon_ax[a].imax));
        push_stat(k + int'(W_ISUM), mon_ax[a].isum);
        push_stat(k + int'(W_ICNT), 64'(mon_ax[a].icnt));
        push_stat(k + int'(W_LMIN), 64'(mon_ax[a].lcnt != 0 ? mon_ax[a].lmin : 32'd0));
        push_stat(k + int'(W_LMAX), 64'(mon_ax[a].lmax));
        push_stat(k + int'(W_LSUM), mon_ax[a].lsum);
        push_stat(k + int'(W_LCNT), 64'(mon_ax[a].lcnt));
        push_stat(k + int'(W_HBCNT), 64'(mon_ax[a].hbcnt));
        push_stat(k + int'(W_ERR), 64'(mon_ax[a].err));
        push_stat(k + int'(W_MODE), 64'(mon_ax[a].mode));
        push_stat(k + int'(W_POS), 64'(mon_ax[a].pos));
        push_stat(k + int'(W_VEL), 64'(mon_ax[a].vel));
      end
      clear_window_model();
    end
  endfunction

  // sends one event, holding valid until the transfer
  task automatic send_event(logic [1:0] cmd, logic [10:0] id, logic [3:0] len,
                            logic [31:0] lo, logic [31:0] hi, logic txa, logic txok,
                            logic [31:0] t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    ev_ch.valid = 1; ev_ch.command = cmd; ev_ch.frame_id = id;
    ev_ch.payload_len = len; ev_ch.data_low = lo; ev_ch.data_high = hi;
    ev_ch.tx_axis = txa; ev_ch.tx_ok = txok; ev_ch.time_us = t;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    predict_event(cmd, id, len, lo, hi, txa, txok, t);
    @(negedge clk);
    ev_ch.valid = 0;
  endtask

  always @(negedge clk) begin
    if (recv_hold) st_ch.ready <= 0;
    else st_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      recv_hold <= 1;
      hold_cycles <= hold_cycles - 1;
    end else recv_hold <= 0;
  end

  always @(posedge clk) begin
    stat_word_t w;
    if (rst_n && st_ch.valid && st_ch.ready) begin
      if (stat_expected.size() == 0) begin
        $error("unexpected stat word index %0d", st_ch.stat_index);
        fail_count++;
      end else begin
        w = stat_expected.pop_front();
        if (st_ch.stat_index !== w.idx) begin
          $error("stat_index expected %0d actual %0d", w.idx, st_ch.stat_index);
          fail_count++;
        end
        if (st_ch.stat_value !== w.value) begin
          $error("stat_value expected %h actual %h", w.value, st_ch.stat_value);
          fail_count++;
        end
        if (st_ch.last !== w.last) begin
          $error("last expected %0d actual %0d", w.last, st_ch.last);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (stat_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    wait_drained();
    psel <= 1; pwrite <= 1; paddr <= REG_LIMIT; pwdata <= v; penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    mon_limit = v;
  endtask

  task automatic send_encoder(int n, logic [31:0] t);
    send_event(CMD_FRAME, {n[5:0], CNUM_ENCODER}, 4'd8, $urandom, $urandom, 0, 0, t);
  endtask

  task automatic send_snapshot();
    send_event(CMD_SNAP, 11'($urandom), 4'($urandom), $urandom, $urandom, 1'($urandom),
               1'($urandom), $urandom);
  endtask

  task automatic test_directed();
    send_snapshot();
    send_encoder(0, 32'd0);
    send_encoder(0, 32'd100);
    send_encoder(0, 32'hFFFF_FFF0);
    send_encoder(0, 32'd5);
    send_event(CMD_TX, 0, 0, 0, 0, 0, 1, 32'd200);
    send_encoder(0, 32'd250);
    send_event(CMD_TX, 0, 0, 0, 0, 1, 1, 32'd300);
    send_encoder(1, 32'd300);
    send_event(CMD_TX, 0, 0, 0, 0, 1, 0, 32'd301);
    send_event(CMD_TX, 0, 0, 0, 0, 1, 1, 32'd400);
    send_encoder(1, 32'd400 + 32'd60000);
    send_event(CMD_FRAME, {6'd1, CNUM_HEARTBEAT}, 4'd5, '1, '1, 0, 0, 32'd9);
    send_event(CMD_FRAME, {6'd0, CNUM_HEARTBEAT}, 4'd4, '1, '1, 0, 0, 32'd9);
    send_event(CMD_FRAME, {6'd0, CNUM_ENCODER}, 4'd7, '1, '1, 0, 0, 32'd900);
    send_event(CMD_FRAME, {6'd0, CNUM_ENCODER}, 4'd15, '1, '1, 0, 0, '1);
    send_event(CMD_FRAME, {6'd2, CNUM_ENCODER}, 4'd8, '1, '1, 0, 0, 32'd50);
    send_event(CMD_FRAME, 11'h7FF, 4'd15, '1, '1, 1, 1, '1);
    send_event(CMD_FRAME, {6'd0, 5'd3}, 4'd8, '1, '1, 0, 0, 32'd60);
    send_event(2'd3, 11'h7FF, 4'd15, '1, '1, 1, 1, '1);
    send_snapshot();
    send_snapshot();
  endtask

  task automatic test_limit_extremes();
    write_limit(32'd0);
    send_event(CMD_TX, 0, 0, 0, 0, 0, 1, 32'd10);
    send_encoder(0, 32'd11);
    send_snapshot();
    write_limit(32'hFFFF_FFFF);
    send_event(CMD_TX, 0, 0, 0, 0, 0, 1, 32'd1);
    send_encoder(0, 32'hFFFF_FFFF);
    send_event(CMD_TX, 0, 0, 0, 0, 0, 1, 32'd0);
    send_encoder(0, 32'd20);
    send_snapshot();
    write_limit(32'd1);
    send_event(CMD_TX, 0, 0, 0, 0, 1, 1, 32'd50);
    send_encoder(1, 32'd51);
    send_snapshot();
    write_limit(LIMIT_RESET);
  endtask

  // mostly well-formed traffic for the watched nodes, with some noise
  task automatic random_event();
    int r;
    int n;
    r = $urandom_range(99);
    n = $urandom_range(1);
    now_us = now_us + $urandom_range(3000);
    if ($urandom_range(49) == 0) now_us = $urandom;
    if (r < 40) send_encoder(n, now_us);
    else if (r < 55)
      send_event(CMD_FRAME, {n[5:0], CNUM_HEARTBEAT}, 4'($urandom_range(5, 15)), $urandom,
                 $urandom, 0, 0, now_us);
    else if (r < 75)
      send_event(CMD_TX, 11'($urandom), 4'($urandom), $urandom, $urandom, 1'(n),
                 $urandom_range(3) != 0, now_us);
    else if (r < 82) send_snapshot();
    else
      send_event(2'($urandom), 11'($urandom), 4'($urandom), $urandom, $urandom,
                 1'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) random_event();
    send_snapshot();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) random_event();
    send_snapshot();
    send_snapshot();
    wait_drained();
    for (int i = 0; i < 10; i++) random_event();
  endtask

  initial begin
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    ev_ch.valid = 0; ev_ch.command = '0; ev_ch.frame_id = '0; ev_ch.payload_len = '0;
    ev_ch.data_low = '0; ev_ch.data_high = '0; ev_ch.tx_axis = 0; ev_ch.tx_ok = 0;
    ev_ch.time_us = '0;
    st_ch.ready = 0;
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_directed();
    test_limit_extremes();
    send_idle_pct = 35; recv_idle_pct = 55;
    test_random(100);
    write_limit($urandom_range(5000));
    send_idle_pct = 55; recv_idle_pct = 35;
    test_random(100);
    write_limit(32'd2500);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(80);
    test_backpressure();
    send_snapshot();
    wait_drained();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
